### design/lbaa_pkg.sv
package lbaa_pkg;

	localparam int CFG_ADDR_BITS = 3;
	localparam int WIDTH_REG_BITS = 11;
	localparam int NEIGH_SLOTS = 4;

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_IMAGE_WIDTH = 1'b0;
	localparam reg_idx_t REG_NEIGH_EIGHT = 1'b1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// neighbour slots in issue order
	localparam int SLOT_LEFT = 0;
	localparam int SLOT_UP = 1;
	localparam int SLOT_UPLEFT = 2;
	localparam int SLOT_UPRIGHT = 3;

	typedef struct packed {
		logic valid;
		logic query;
	} issue_t;

	typedef struct packed {
		logic clr_busy;
		logic query_ok;
	} tbl_stat_t;

endpackage

### design/lbaa_req_if.sv
interface lbaa_req_if #(
	parameter int LABEL_BITS = 8
);
	logic                  valid;
	logic                  ready;
	logic                  req_type;
	logic [LABEL_BITS-1:0] pixel_label;
	logic                  frame_start;
	logic [LABEL_BITS-1:0] query_label_a;
	logic [LABEL_BITS-1:0] query_label_b;

	modport source(output valid, req_type, pixel_label, frame_start, query_label_a,
		query_label_b, input ready);
	modport sink(input valid, req_type, pixel_label, frame_start, query_label_a,
		query_label_b, output ready);
endinterface

### design/lbaa_rsp_if.sv
interface lbaa_rsp_if #(
	parameter int LABEL_BITS = 8,
	parameter int COUNT_BITS = 24
);
	logic                  valid;
	logic                  ready;
	logic [COUNT_BITS-1:0] edge_count;
	logic [LABEL_BITS-1:0] min_label;
	logic [LABEL_BITS-1:0] max_label;
	logic                  has_edges;

	modport source(output valid, edge_count, min_label, max_label, has_edges, input ready);
	modport sink(input valid, edge_count, min_label, max_label, has_edges, output ready);
endinterface

### design/label_adjacency_accumulator_unit.sv
// Region adjacency counter over a raster stream of region labels.
// req: one item per pixel (req_type 0, frame_start on the first pixel of a
//   frame) or per count read (req_type 1, query_label_a/b). valid/ready.
// rsp: one item per count read, in order, carrying the pair's saturating
//   count and the smallest/largest label seen on any edge this frame.
// APB port: image_width at 0x0, neighborhood_eight at 0x4; pready tied high.
// Table use: a pixel makes one pair-table access per unequal neighbour it
//   has (0 to 4), all through the single read-modify-write port of the
//   pair table; a pixel with no unequal neighbour makes none. A read is
//   not issued while the read before it is still in the table stage.
// Path: a read's item passes the front stage, the table stage and the
//   output register before it is valid on rsp.
// The pair table stores one entry per unordered pair, 2**(2*LABEL_BITS) deep.
// Reset, and every frame_start pixel, runs a clearing pass over all
//   2**(2*LABEL_BITS) entries (after a frame start, behind CLR_WAIT) during
//   which req.ready is low; configuration writes are still taken.
// A stalled rsp holds its item; the next read then waits at the front and
//   holds up the items behind it.
module label_adjacency_accumulator_unit #(
	parameter int LABEL_BITS = 8,
	parameter int MAX_WIDTH = 1024,
	parameter int COUNT_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	lbaa_req_if.sink                             req,
	lbaa_rsp_if.source                           rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lbaa_pkg::CFG_ADDR_BITS-1:0]   paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import lbaa_pkg::*;

	logic [WIDTH_REG_BITS-1:0] image_width_q;
	logic                      eight_q;
	reg_idx_t                  idx;
	issue_t                    iss;
	tbl_stat_t                 stat;
	logic [2*LABEL_BITS-1:0]   iss_addr;
	logic                      clear_start;

	assign pready = 1'b1;
	assign idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_REG_BITS'(640);
			eight_q <= 1'b1;
		end else if (psel && penable && pwrite && pready) begin
			case (idx)
				REG_IMAGE_WIDTH: image_width_q <= pwdata[WIDTH_REG_BITS-1:0];
				REG_NEIGH_EIGHT: eight_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_IMAGE_WIDTH: prdata = 32'(image_width_q);
			REG_NEIGH_EIGHT: prdata = 32'(eight_q);
			default: prdata = '0;
		endcase
	end

	lbaa_front #(
		.LABEL_BITS(LABEL_BITS),
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.image_width(image_width_q),
		.neighborhood_eight(eight_q),
		.stat(stat),
		.iss(iss),
		.iss_addr(iss_addr),
		.clear_start(clear_start)
	);

	lbaa_rmw #(
		.LABEL_BITS(LABEL_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_rmw (
		.clk(clk),
		.arst_n(arst_n),
		.iss(iss),
		.iss_addr(iss_addr),
		.clear_start(clear_start),
		.stat(stat),
		.rsp(rsp)
	);
endmodule

### design/lbaa_front.sv
module lbaa_front #(
	parameter int LABEL_BITS = 8,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	lbaa_req_if.sink                               req,
	input  logic [lbaa_pkg::WIDTH_REG_BITS-1:0]    image_width,
	input  logic                                   neighborhood_eight,
	input  lbaa_pkg::tbl_stat_t                    stat,
	output lbaa_pkg::issue_t                       iss,
	output logic [2*LABEL_BITS-1:0]                iss_addr,
	output logic                                   clear_start
);
	import lbaa_pkg::*;

	localparam int XB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int LB = LABEL_BITS;

	logic [LB-1:0] row_mem [MAX_WIDTH];

	logic [XB-1:0] col_q;
	logic          first_q;
	logic [LB-1:0] left_q;
	logic [LB-1:0] up_q;
	logic [LB-1:0] ur_q;

	logic                   s1_valid_q;
	logic                   s1_query_q;
	logic [NEIGH_SLOTS-1:0] s1_cand_q;
	logic [NEIGH_SLOTS-1:0] s1_done_q;
	logic [LB-1:0]          s1_p_q;
	logic [LB-1:0]          s1_left_q;
	logic [LB-1:0]          s1_upleft_q;
	logic [2*LB-1:0]        s1_qaddr_q;

	logic [WB-1:0]          w;
	logic [XB-1:0]          x;
	logic                   fr0;
	logic [WB-1:0]          nx;
	logic [XB-1:0]          ur_idx;
	logic [NEIGH_SLOTS-1:0] cand;
	logic                   accept;
	logic                   pix_acc;

	logic [LB-1:0]          nb [NEIGH_SLOTS];
	logic [NEIGH_SLOTS-1:0] pend;
	logic [NEIGH_SLOTS-1:0] sel;
	logic [LB-1:0]          n_sel;
	logic                   can_issue;
	logic                   last;
	logic                   free;

	always_comb begin
		if (image_width == '0) begin
			w = WB'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			w = WB'(MAX_WIDTH);
		end else begin
			w = WB'(image_width);
		end
		x = req.frame_start ? '0 : col_q;
		fr0 = req.frame_start | first_q;
		if (WB'(x) >= w) begin
			x = '0;
			fr0 = 1'b0;
		end
		nx = WB'(x) + WB'(1);
		ur_idx = (nx < w) ? XB'(nx) : x;
		cand[SLOT_LEFT] = (x != '0);
		cand[SLOT_UP] = !fr0;
		cand[SLOT_UPLEFT] = !fr0 && neighborhood_eight && (x != '0);
		cand[SLOT_UPRIGHT] = !fr0 && neighborhood_eight && (nx < w);
	end

	always_comb begin
		nb[SLOT_LEFT] = s1_left_q;
		nb[SLOT_UP] = up_q;
		nb[SLOT_UPLEFT] = s1_upleft_q;
		nb[SLOT_UPRIGHT] = ur_q;
		if (s1_query_q) begin
			pend = {{(NEIGH_SLOTS-1){1'b0}}, !s1_done_q[0]};
		end else begin
			for (int i = 0; i < NEIGH_SLOTS; i++) begin
				pend[i] = s1_cand_q[i] && (nb[i] != s1_p_q) && !s1_done_q[i];
			end
		end
		sel = pend & (~pend + NEIGH_SLOTS'(1));
		n_sel = '0;
		for (int i = 0; i < NEIGH_SLOTS; i++) begin
			if (sel[i]) begin
				n_sel = nb[i];
			end
		end
		can_issue = s1_valid_q && !stat.clr_busy && (pend != '0) &&
			(!s1_query_q || stat.query_ok);
		last = ($countones(pend) <= 1);
		free = !s1_valid_q || (pend == '0) || (can_issue && last);
	end

	assign req.ready = free && !stat.clr_busy;
	assign accept = req.valid && req.ready;
	assign pix_acc = accept && (req.req_type == REQ_PIXEL);
	assign clear_start = pix_acc && req.frame_start;

	assign iss.valid = can_issue;
	assign iss.query = s1_query_q;
	always_comb begin
		if (s1_query_q) begin
			iss_addr = s1_qaddr_q;
		end else if (s1_p_q < n_sel) begin
			iss_addr = {s1_p_q, n_sel};
		end else begin
			iss_addr = {n_sel, s1_p_q};
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			row_mem[x] <= req.pixel_label;
			up_q <= row_mem[x];
			ur_q <= row_mem[ur_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_p_q <= req.pixel_label;
			s1_left_q <= left_q;
			s1_upleft_q <= up_q;
			s1_cand_q <= cand;
			if (req.query_label_a < req.query_label_b) begin
				s1_qaddr_q <= {req.query_label_a, req.query_label_b};
			end else begin
				s1_qaddr_q <= {req.query_label_b, req.query_label_a};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_q <= 1'b1;
			left_q <= '0;
			s1_valid_q <= 1'b0;
			s1_query_q <= 1'b0;
			s1_done_q <= '0;
		end else begin
			if (pix_acc) begin
				left_q <= req.pixel_label;
				if (nx >= w) begin
					col_q <= '0;
					first_q <= 1'b0;
				end else begin
					col_q <= XB'(nx);
					first_q <= fr0;
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
				s1_query_q <= req.req_type;
				s1_done_q <= '0;
			end else if (can_issue) begin
				s1_done_q <= s1_done_q | sel;
				if (last) begin
					s1_valid_q <= 1'b0;
				end
			end
		end
	end
endmodule

### design/lbaa_rmw.sv
module lbaa_rmw #(
	parameter int LABEL_BITS = 8,
	parameter int COUNT_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lbaa_pkg::issue_t            iss,
	input  logic [2*LABEL_BITS-1:0]     iss_addr,
	input  logic                        clear_start,
	output lbaa_pkg::tbl_stat_t         stat,
	lbaa_rsp_if.source                  rsp
);
	import lbaa_pkg::*;

	localparam int LB = LABEL_BITS;
	localparam int AB = 2 * LABEL_BITS;

	typedef enum logic [1:0] {CLR_IDLE, CLR_WAIT, CLR_RUN} clr_state_t;

	logic [COUNT_BITS-1:0] tbl_mem [2**AB];

	clr_state_t            clr_q;
	logic [AB-1:0]         clr_cnt_q;
	logic                  s2_valid_s2;
	logic                  s2_query_s2;
	logic [AB-1:0]         s2_addr_s2;
	logic                  s2_fwd_s2;
	logic [COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0] wr_q;
	logic [LB-1:0]         lowest_q;
	logic [LB-1:0]         highest_q;
	logic                  any_q;
	logic                  out_valid_q;

	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] inc;
	logic                  s2_edge;
	logic                  we;
	logic [AB-1:0]         wa;
	logic [COUNT_BITS-1:0] wd;
	logic [LB-1:0]         lo;
	logic [LB-1:0]         hi;

	assign s2_edge = s2_valid_s2 && !s2_query_s2;
	assign cur = s2_fwd_s2 ? wr_q : rd_q;
	assign inc = (cur == '1) ? cur : cur + COUNT_BITS'(1);
	assign lo = s2_addr_s2[AB-1:LB];
	assign hi = s2_addr_s2[LB-1:0];

	always_comb begin
		if (clr_q == CLR_RUN) begin
			we = 1'b1;
			wa = clr_cnt_q;
			wd = '0;
		end else begin
			we = s2_edge;
			wa = s2_addr_s2;
			wd = inc;
		end
	end

	assign stat.clr_busy = (clr_q != CLR_IDLE);
	assign stat.query_ok = !(s2_valid_s2 && s2_query_s2) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk) begin
		if (we) begin
			tbl_mem[wa] <= wd;
		end
		if (iss.valid) begin
			rd_q <= tbl_mem[iss_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (iss.valid) begin
			s2_addr_s2 <= iss_addr;
			s2_query_s2 <= iss.query;
			s2_fwd_s2 <= s2_edge && (iss_addr == s2_addr_s2);
		end
		if (s2_edge) begin
			wr_q <= inc;
		end
		if (s2_valid_s2 && s2_query_s2) begin
			rsp.edge_count <= cur;
			rsp.min_label <= lowest_q;
			rsp.max_label <= highest_q;
			rsp.has_edges <= any_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= CLR_RUN;
			clr_cnt_q <= '0;
			s2_valid_s2 <= 1'b0;
			lowest_q <= '1;
			highest_q <= '0;
			any_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			s2_valid_s2 <= iss.valid;
			if (s2_valid_s2 && s2_query_s2) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (s2_edge) begin
				if (lo < lowest_q) begin
					lowest_q <= lo;
				end
				if (hi > highest_q) begin
					highest_q <= hi;
				end
				any_q <= 1'b1;
			end
			case (clr_q)
				CLR_IDLE: begin
					if (clear_start) begin
						clr_q <= CLR_WAIT;
					end
				end
				CLR_WAIT: begin
					clr_q <= CLR_RUN;
					clr_cnt_q <= '0;
					lowest_q <= '1;
					highest_q <= '0;
					any_q <= 1'b0;
				end
				CLR_RUN: begin
					clr_cnt_q <= clr_cnt_q + AB'(1);
					if (clr_cnt_q == '1) begin
						clr_q <= CLR_IDLE;
					end
				end
				default: begin
					clr_q <= CLR_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
endmodule

### test/tb_label_adjacency_accumulator_unit.sv
`timescale 1ns / 1ps

module tb_label_adjacency_accumulator_unit;
	import lbaa_pkg::*;

	localparam int LBITS = 8;
	localparam int CBITS = 24;
	localparam int WMAX = 1024;
	localparam int PIX_SETTLE = 40;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		logic             kind;
		logic [LBITS-1:0] label;
		logic             fstart;
		logic [LBITS-1:0] qa;
		logic [LBITS-1:0] qb;
	} label_item_t;

	typedef struct {
		logic [CBITS-1:0] cnt;
		logic [LBITS-1:0] lo;
		logic [LBITS-1:0] hi;
		logic             any;
	} count_reply_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [31:0] pwdata, prdata;

	lbaa_req_if #(.LABEL_BITS(LBITS)) req_bus();
	lbaa_rsp_if #(.LABEL_BITS(LBITS), .COUNT_BITS(CBITS)) rsp_bus();

	label_adjacency_accumulator_unit #(
		.LABEL_BITS(LBITS),
		.MAX_WIDTH(WMAX),
		.COUNT_BITS(CBITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// shadow of the block
	logic [CBITS-1:0] adj_cnt [0:(1<<(2*LBITS))-1];
	logic [LBITS-1:0] line_buf [0:WMAX-1];
	logic [LBITS-1:0] ul_lbl, lf_lbl, lo_lbl, hi_lbl;
	int unsigned col;
	logic top_row, seen_edge;
	logic [WIDTH_REG_BITS-1:0] width_reg;
	logic eight_reg;

	label_item_t pend_items[$];
	count_reply_t due_counts[$];
	int unsigned n_queued, n_taken, n_errs;
	longint cycles;
	logic req_took;
	int burst_left, gap_left, stall_mode, stall_left;
	logic [LBITS-1:0] palette [0:3];

	function automatic void clear_frame();
		foreach (adj_cnt[i]) adj_cnt[i] = '0;
		lo_lbl = '1;
		hi_lbl = '0;
		seen_edge = 1'b0;
		col = 0;
		top_row = 1'b1;
	endfunction

	function automatic void bump_pair(logic [LBITS-1:0] r, logic [LBITS-1:0] c);
		if (adj_cnt[{r, c}] != '1)
			adj_cnt[{r, c}] = adj_cnt[{r, c}] + 1'b1;
	endfunction

	function automatic void link(logic [LBITS-1:0] p, logic [LBITS-1:0] n);
		if (p != n) begin
			bump_pair(p, n);
			bump_pair(n, p);
			if (p < lo_lbl) lo_lbl = p;
			if (n < lo_lbl) lo_lbl = n;
			if (p > hi_lbl) hi_lbl = p;
			if (n > hi_lbl) hi_lbl = n;
			seen_edge = 1'b1;
		end
	endfunction

	function automatic void absorb_pixel(logic [LBITS-1:0] p, logic fs);
		int unsigned w, x;
		logic [LBITS-1:0] up;
		w = (width_reg == 0) ? 1 : (width_reg > WMAX) ? WMAX : 32'(width_reg);
		if (fs)
			clear_frame();
		if (col >= w) begin
			col = 0;
			top_row = 1'b0;
		end
		x = col;
		up = line_buf[x];
		if (x > 0)
			link(p, lf_lbl);
		if (!top_row) begin
			link(p, up);
			if (eight_reg) begin
				if (x > 0)
					link(p, ul_lbl);
				if (x + 1 < w)
					link(p, line_buf[x+1]);
			end
		end
		line_buf[x] = p;
		ul_lbl = up;
		lf_lbl = p;
		col = x + 1;
		if (col >= w) begin
			col = 0;
			top_row = 1'b0;
		end
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		n_errs++;
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_BITS'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = val[WIDTH_REG_BITS-1:0];
		else
			eight_reg = val[0];
	endtask

	task automatic push_pixel(logic [LBITS-1:0] p, logic fs);
		label_item_t it;
		it.kind = REQ_PIXEL;
		it.label = p;
		it.fstart = fs;
		it.qa = LBITS'($urandom);
		it.qb = LBITS'($urandom);
		pend_items.push_back(it);
		n_queued++;
	endtask

	task automatic push_query(logic [LBITS-1:0] a, logic [LBITS-1:0] b);
		label_item_t it;
		it.kind = REQ_QUERY;
		it.label = LBITS'($urandom);
		it.fstart = 1'($urandom);
		it.qa = a;
		it.qb = b;
		pend_items.push_back(it);
		n_queued++;
	endtask

	task automatic drain();
		while (!(n_taken == n_queued && due_counts.size() == 0))
			@(posedge clk);
		repeat (PIX_SETTLE) @(posedge clk);
	endtask

	function automatic logic [LBITS-1:0] pick_label();
		if ($urandom_range(0, 9) < 8)
			return palette[$urandom_range(0, 3)];
		return LBITS'($urandom);
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// request driver, pixels and count reads
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (req_bus.valid && !req_took) begin
		end else if (gap_left > 0) begin
			req_bus.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (pend_items.size() > 0) begin
			label_item_t it;
			it = pend_items.pop_front();
			req_bus.valid <= 1'b1;
			req_bus.req_type <= it.kind;
			req_bus.pixel_label <= it.label;
			req_bus.frame_start <= it.fstart;
			req_bus.query_label_a <= it.qa;
			req_bus.query_label_b <= it.qb;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			req_bus.valid <= 1'b0;
		end
	end

	// reply stall pattern
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_bus.ready <= 1'b1;
			1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
			default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	// monitor and prediction
	always @(posedge clk) begin
		cycles <= cycles + 1;
		req_took <= req_bus.valid && req_bus.ready;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			count_reply_t want;
			if (due_counts.size() == 0) begin
				report("unexpected item", rsp_bus.edge_count, -1);
			end else begin
				want = due_counts.pop_front();
				if (rsp_bus.edge_count !== want.cnt)
					report("edge_count", rsp_bus.edge_count, want.cnt);
				if (rsp_bus.min_label !== want.lo)
					report("min_label", rsp_bus.min_label, want.lo);
				if (rsp_bus.max_label !== want.hi)
					report("max_label", rsp_bus.max_label, want.hi);
				if (rsp_bus.has_edges !== want.any)
					report("has_edges", rsp_bus.has_edges, want.any);
			end
		end
		if (arst_n && req_bus.valid && req_bus.ready) begin
			n_taken <= n_taken + 1;
			if (req_bus.req_type == REQ_QUERY) begin
				count_reply_t r;
				r.cnt = adj_cnt[{req_bus.query_label_a, req_bus.query_label_b}];
				r.lo = lo_lbl;
				r.hi = hi_lbl;
				r.any = seen_edge;
				due_counts.push_back(r);
			end else begin
				absorb_pixel(req_bus.pixel_label, req_bus.frame_start);
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_PIXEL;
		req_bus.pixel_label = '0;
		req_bus.frame_start = 1'b0;
		req_bus.query_label_a = '0;
		req_bus.query_label_b = '0;
		rsp_bus.ready = 1'b0;
		req_took = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		stall_left = 0;
		n_queued = 0;
		n_taken = 0;
		n_errs = 0;
		cycles = 0;
		clear_frame();
		foreach (line_buf[i]) line_buf[i] = '0;
		ul_lbl = '0;
		lf_lbl = '0;
		width_reg = WIDTH_REG_BITS'(640);
		eight_reg = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values, no edges yet, label extremes
		push_query(8'd0, 8'd0);
		push_pixel(8'd0, 1'b1);
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd255, 1'b0);
		push_pixel(8'd0, 1'b0);
		push_pixel(8'd7, 1'b0);
		push_query(8'd0, 8'd255);
		push_query(8'd255, 8'd0);
		push_query(8'd255, 8'd7);
		push_query(8'd3, 8'd3);
		drain();

		// shrink mid-row: the row closes before the next pixel
		apb_write(REG_IMAGE_WIDTH, 32'd3);
		push_pixel(8'd1, 1'b0);
		push_pixel(8'd2, 1'b0);
		push_pixel(8'd1, 1'b0);
		push_pixel(8'd2, 1'b0);
		push_pixel(8'd2, 1'b0);
		push_pixel(8'd2, 1'b0);
		push_query(8'd1, 8'd0);
		push_query(8'd2, 8'd255);
		push_query(8'd1, 8'd2);
		drain();

		// width 0 taken as 1, 4-neighbourhood
		apb_write(REG_NEIGH_EIGHT, 32'd0);
		apb_write(REG_IMAGE_WIDTH, 32'd0);
		push_pixel(8'd9, 1'b1);
		push_pixel(8'd10, 1'b0);
		push_pixel(8'd9, 1'b0);
		push_pixel(8'd9, 1'b0);
		push_pixel(8'd200, 1'b0);
		push_query(8'd9, 8'd10);
		push_query(8'd200, 8'd9);
		drain();

		// width above the maximum taken as the maximum
		apb_write(REG_IMAGE_WIDTH, 32'h7FF);
		apb_write(REG_NEIGH_EIGHT, 32'd1);
		foreach (palette[i]) palette[i] = LBITS'($urandom);
		push_pixel(pick_label(), 1'b1);
		for (int i = 0; i < 30; i++)
			push_pixel(pick_label(), 1'b0);
		push_query(palette[0], palette[1]);
		push_query(palette[2], palette[3]);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			apb_write(REG_IMAGE_WIDTH, (ph == 4) ? 32'd1024 : 32'($urandom_range(1, 12)));
			apb_write(REG_NEIGH_EIGHT, (ph < 2) ? 32'(ph) : 32'($urandom_range(0, 1)));
			foreach (palette[i])
				palette[i] = ($urandom_range(0, 5) == 0) ?
					(($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0) : LBITS'($urandom);
			push_pixel(pick_label(), 1'b1);
			n = 0;
			while (n < 120) begin
				if ($urandom_range(0, 3) == 0) begin
					if ($urandom_range(0, 4) == 0)
						push_query(LBITS'($urandom), LBITS'($urandom));
					else
						push_query(pick_label(), pick_label());
				end else begin
					push_pixel(pick_label(), 1'b0);
				end
				n++;
			end
			drain();
		end

		if (n_errs == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
